>>> src/irlw_pkg.sv
// shared types and constants for the ir level window full detector
package irlw_pkg;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_ARM   = 3'd3,
		CMD_ICE   = 3'd4
	} cmd_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRA_CHECKS    = 3'd3;

	localparam logic [11:0] RST_LEVEL_THRESHOLD = 12'd300;
	localparam logic [7:0]  RST_WINDOW_TICKS    = 8'd100;
	localparam logic [7:0]  RST_PASS_COUNT      = 8'd50;
	localparam logic [3:0]  RST_EXTRA_CHECKS    = 4'd2;

	localparam logic [7:0] HIGH_SAMPLES_MAX = 8'hFF;

	typedef struct packed {
		logic [3:0] pending_checks;
		logic       first_check_done;
		logic       emitter_on;
		logic       checking;
		logic       weak_full;
		logic       full_res;
	} status_t;

endpackage

>>> src/irlw_core.sv
// detector state, configuration registers and next-state logic
module irlw_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [irlw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irlw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              step,
	input  logic [2:0]                        command,
	input  logic [11:0]                       adc_sample,
	output irlw_pkg::status_t                 status_next
);

	logic [11:0] level_threshold_q;
	logic [7:0]  window_ticks_q;
	logic [7:0]  pass_count_q;
	logic [3:0]  extra_checks_q;

	logic       running_q, emitter_q, full_q, weak_q, done_q;
	logic [7:0] ticks_left_q, high_samples_q;
	logic [3:0] pending_q;

	logic       running_d, emitter_d, full_d, weak_d, done_d;
	logic [7:0] ticks_left_d, high_samples_d;
	logic [3:0] pending_d;
	logic [7:0] hs_inc;
	logic [7:0] ticks_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_threshold_q <= irlw_pkg::RST_LEVEL_THRESHOLD;
			window_ticks_q    <= irlw_pkg::RST_WINDOW_TICKS;
			pass_count_q      <= irlw_pkg::RST_PASS_COUNT;
			extra_checks_q    <= irlw_pkg::RST_EXTRA_CHECKS;
		end else if (cfg_we) begin
			case (cfg_index)
				irlw_pkg::REG_LEVEL_THRESHOLD: level_threshold_q <= cfg_data[11:0];
				irlw_pkg::REG_WINDOW_TICKS:    window_ticks_q    <= cfg_data[7:0];
				irlw_pkg::REG_PASS_COUNT:      pass_count_q      <= cfg_data[7:0];
				irlw_pkg::REG_EXTRA_CHECKS:    extra_checks_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// saturating count of high samples and window countdown
	assign hs_inc = ((adc_sample >= level_threshold_q)
		&& (high_samples_q != irlw_pkg::HIGH_SAMPLES_MAX))
		? high_samples_q + 8'd1 : high_samples_q;
	assign ticks_dec = ticks_left_q - 8'd1;

	always_comb begin
		running_d      = running_q;
		emitter_d      = emitter_q;
		full_d         = full_q;
		weak_d         = weak_q;
		done_d         = done_q;
		ticks_left_d   = ticks_left_q;
		high_samples_d = high_samples_q;
		pending_d      = pending_q;
		case (command)
			irlw_pkg::CMD_TICK: begin
				if (running_q && !emitter_q) begin
					emitter_d      = 1'b1;
					ticks_left_d   = window_ticks_q;
					high_samples_d = '0;
				end else if (running_q) begin
					high_samples_d = hs_inc;
					ticks_left_d   = ticks_dec;
					if (ticks_dec == 8'd0) begin
						running_d = 1'b0;
						emitter_d = 1'b0;
						done_d    = 1'b1;
						if (hs_inc >= pass_count_q) begin
							weak_d    = 1'b0;
							full_d    = 1'b0;
							pending_d = '0;
						end else begin
							weak_d = 1'b1;
							if (pending_q == 4'd0)
								full_d = 1'b1;
						end
					end
				end
			end
			irlw_pkg::CMD_START: running_d = 1'b1;
			irlw_pkg::CMD_STOP:  running_d = 1'b0;
			irlw_pkg::CMD_ARM: begin
				if (pending_q == 4'd0)
					pending_d = extra_checks_q;
			end
			irlw_pkg::CMD_ICE: begin
				if (weak_q && pending_q != 4'd0)
					pending_d = pending_q - 4'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q      <= 1'b1;
			emitter_q      <= 1'b0;
			full_q         <= 1'b0;
			weak_q         <= 1'b0;
			done_q         <= 1'b0;
			ticks_left_q   <= irlw_pkg::RST_WINDOW_TICKS;
			high_samples_q <= '0;
			pending_q      <= '0;
		end else if (step) begin
			running_q      <= running_d;
			emitter_q      <= emitter_d;
			full_q         <= full_d;
			weak_q         <= weak_d;
			done_q         <= done_d;
			ticks_left_q   <= ticks_left_d;
			high_samples_q <= high_samples_d;
			pending_q      <= pending_d;
		end
	end

	assign status_next.full_res         = full_d;
	assign status_next.weak_full        = weak_d;
	assign status_next.checking         = running_d;
	assign status_next.emitter_on       = emitter_d;
	assign status_next.first_check_done = done_d;
	assign status_next.pending_checks   = pending_d;

endmodule

>>> src/ir_level_window_full_detector_top.sv
// top level of the ir level window full detector
//
// windowed level qualifier for an infrared light-barrier sensor.
// input channel s_*: one transfer per command; s_tuser carries the command
// (tick, start, stop, arm, ice made), s_tdata the converter sample.
// output channel m_*: exactly one transfer per input transfer, giving the
// status after that command (full, weak full, checking, emitter, first
// check done, pending checks).
// the status is on m_tdata in the cycle after the input transfer.
// throughput: one command per cycle while m_tready is high; the state update
// is compare and counter logic between the state and output registers.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled receiver holds m_tdata and stops new input after one item.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// indexes beyond the four registers are ignored.
// reset: registers return to their defaults, a check is running with the
// emitter off, and the output register is empty.
module ir_level_window_full_detector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [irlw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irlw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,  // adc_sample[11:0], zero pad
	input  logic [2:0]                      s_tuser,  // command[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata   // full_res, weak_full, checking,
	                                                  // emitter_on, first_check_done,
	                                                  // pending_checks[3:0], zero pad
);

	irlw_pkg::status_t status_next;
	irlw_pkg::status_t status_q;
	logic              out_valid_q;
	logic              step;

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	irlw_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.step        (step),
		.command     (s_tuser),
		.adc_sample  (s_tdata[11:0]),
		.status_next (status_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_q <= status_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, status_q};

endmodule

>>> src/irlw_checker.sv
// port-level checks for the ir level window full detector, bound to the top
module irlw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after input transfer");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output held");

	a_full_weak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[0] || m_tdata[1])
		else $error("full without weak full");

endmodule

bind ir_level_window_full_detector_top irlw_checker u_irlw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
